// ===== src/ibed_pkg.sv =====
// ----------------------------------------------------------------------------
// ibed_pkg
// Shared types and constants of the infrared burst echo detector.
// ----------------------------------------------------------------------------
`default_nettype none

package ibed_pkg;

   localparam int unsigned CsrIndexWidth = 3;
   localparam int unsigned CsrDataWidth  = 8;

   localparam logic [CsrIndexWidth-1:0] CSR_TICKS_PER_MS     = 3'd0;
   localparam logic [CsrIndexWidth-1:0] CSR_PULSES_PER_BURST = 3'd1;
   localparam logic [CsrIndexWidth-1:0] CSR_BURSTS_PER_ROUND = 3'd2;
   localparam logic [CsrIndexWidth-1:0] CSR_PASS_THRESHOLD   = 3'd3;
   localparam logic [CsrIndexWidth-1:0] CSR_PING_GAP_MS      = 3'd4;
   localparam logic [CsrIndexWidth-1:0] CSR_PRESS_HOLD_MS    = 3'd5;

   localparam logic [7:0] RESET_TICKS_PER_MS     = 8'd38;
   localparam logic [7:0] RESET_PULSES_PER_BURST = 8'd16;
   localparam logic [3:0] RESET_BURSTS_PER_ROUND = 4'd8;
   localparam logic [3:0] RESET_PASS_THRESHOLD   = 4'd6;
   localparam logic [7:0] RESET_PING_GAP_MS      = 8'd10;
   localparam logic [7:0] RESET_PRESS_HOLD_MS    = 8'd50;

   typedef struct packed {
      logic [7:0] ticks_per_ms;
      logic [7:0] pulses_per_burst;
      logic [3:0] bursts_per_round;
      logic [3:0] pass_threshold;
      logic [7:0] ping_gap_ms;
      logic [7:0] press_hold_ms;
   } cfg_type;

   typedef struct packed {
      logic       sense_edge;
      logic       key_down;
      logic       running;
      logic [4:0] gap_random;
   } tick_type;

   typedef struct packed {
      logic       carrier_on;
      logic       button_event;
      logic       complete_event;
      logic [3:0] echo_run;
   } result_type;

endpackage : ibed_pkg

`default_nettype wire

// ===== src/ir_burst_echo_detector_unit.sv =====
// Transactions pass from the input register to the result register.
// Throughput: one transaction per cycle unless rsp_ready stalls the result
// register; the round sequencer advances by one tick in the cycle the input
// register hands it on. Synchronous active-high reset clears both register
// stages and the sequencer state and loads the configuration defaults.
// ----------------------------------------------------------------------------
// ir_burst_echo_detector_unit
// Infrared burst echo detector: input register, round sequencer, result
// register and configuration registers.
// ----------------------------------------------------------------------------
`default_nettype none

module ir_burst_echo_detector_unit (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                req_valid,
   output logic                                     req_ready,
   input  wire logic                                req_sense_edge,
   input  wire logic                                req_key_down,
   input  wire logic                                req_running,
   input  wire logic [4:0]                          req_gap_random,
   output logic                                     rsp_valid,
   input  wire logic                                rsp_ready,
   output logic                                     rsp_carrier_on,
   output logic                                     rsp_button_event,
   output logic                                     rsp_complete_event,
   output logic [3:0]                               rsp_echo_run,
   input  wire logic                                csr_we,
   input  wire logic [ibed_pkg::CsrIndexWidth-1:0]  csr_index,
   input  wire logic [ibed_pkg::CsrDataWidth-1:0]   csr_wdata
);
   import ibed_pkg::*;

   cfg_type    cfg;
   tick_type   tick_ff;
   logic       tick_valid_ff;
   result_type result;
   result_type result_ff;
   logic       rsp_valid_ff;
   logic       advance;

   assign advance   = tick_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !tick_valid_ff || advance;

   ibed_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   ibed_core u_core (
      .clock  (clock),
      .reset  (reset),
      .step   (advance),
      .cfg    (cfg),
      .tick   (tick_ff),
      .result (result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         tick_valid_ff <= 1'b0;
      end else if (req_ready) begin
         tick_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         tick_ff.sense_edge <= req_sense_edge;
         tick_ff.key_down   <= req_key_down;
         tick_ff.running    <= req_running;
         tick_ff.gap_random <= req_gap_random;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         result_ff <= result;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_carrier_on     = result_ff.carrier_on;
   assign rsp_button_event   = result_ff.button_event;
   assign rsp_complete_event = result_ff.complete_event;
   assign rsp_echo_run       = result_ff.echo_run;

endmodule : ir_burst_echo_detector_unit

`default_nettype wire

// ===== src/ibed_csr.sv =====
// ----------------------------------------------------------------------------
// ibed_csr
// Configuration registers, written through a plain write port.
// ----------------------------------------------------------------------------
`default_nettype none

module ibed_csr (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                csr_we,
   input  wire logic [ibed_pkg::CsrIndexWidth-1:0]  csr_index,
   input  wire logic [ibed_pkg::CsrDataWidth-1:0]   csr_wdata,
   output ibed_pkg::cfg_type                        cfg
);
   import ibed_pkg::*;

   cfg_type cfg_ff;
   cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (csr_index)
            CSR_TICKS_PER_MS:     cfg_in.ticks_per_ms     = csr_wdata;
            CSR_PULSES_PER_BURST: cfg_in.pulses_per_burst = csr_wdata;
            CSR_BURSTS_PER_ROUND: cfg_in.bursts_per_round = csr_wdata[3:0];
            CSR_PASS_THRESHOLD:   cfg_in.pass_threshold   = csr_wdata[3:0];
            CSR_PING_GAP_MS:      cfg_in.ping_gap_ms      = csr_wdata;
            CSR_PRESS_HOLD_MS:    cfg_in.press_hold_ms    = csr_wdata;
            default:              cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.ticks_per_ms     <= RESET_TICKS_PER_MS;
         cfg_ff.pulses_per_burst <= RESET_PULSES_PER_BURST;
         cfg_ff.bursts_per_round <= RESET_BURSTS_PER_ROUND;
         cfg_ff.pass_threshold   <= RESET_PASS_THRESHOLD;
         cfg_ff.ping_gap_ms      <= RESET_PING_GAP_MS;
         cfg_ff.press_hold_ms    <= RESET_PRESS_HOLD_MS;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule : ibed_csr

`default_nettype wire

// ===== src/ibed_core.sv =====
// ----------------------------------------------------------------------------
// ibed_core
// Round sequencer: burst, gap and ping timing, echo run length and button
// debounce. Advances by one tick whenever step is high.
// ----------------------------------------------------------------------------
`default_nettype none

module ibed_core (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                step,
   input  wire ibed_pkg::cfg_type   cfg,
   input  wire ibed_pkg::tick_type  tick,
   output ibed_pkg::result_type     result
);
   import ibed_pkg::*;

   localparam logic [1:0] PH_IDLE  = 2'd0;
   localparam logic [1:0] PH_BURST = 2'd1;
   localparam logic [1:0] PH_GAP   = 2'd2;
   localparam logic [1:0] PH_PING  = 2'd3;

   logic [1:0] phase_ff, phase_in;
   logic [7:0] prescale_ff, prescale_in;
   logic [7:0] ms_count_ff, ms_count_in;
   logic [7:0] pulse_count_ff, pulse_count_in;
   logic [3:0] burst_index_ff, burst_index_in;
   logic       echo_seen_ff, echo_seen_in;
   logic [3:0] run_length_ff, run_length_in;
   logic [4:0] gap_length_ff, gap_length_in;
   logic       button_timing_ff, button_timing_in;
   logic       button_reported_ff, button_reported_in;

   logic [7:0] tpm;
   logic [7:0] ppb;
   logic [3:0] bpr;
   logic [7:0] prescale_inc;
   logic       ms_tick;
   logic [7:0] prescale_step;
   logic [7:0] ms_timed;
   logic [7:0] pulse_inc;
   logic       echo_now;

   assign tpm           = (cfg.ticks_per_ms == 8'd0) ? 8'd1 : cfg.ticks_per_ms;
   assign ppb           = (cfg.pulses_per_burst == 8'd0) ? 8'd1 : cfg.pulses_per_burst;
   assign bpr           = (cfg.bursts_per_round == 4'd0) ? 4'd1 : cfg.bursts_per_round;
   assign prescale_inc  = prescale_ff + 8'd1;
   assign ms_tick       = (prescale_inc >= tpm);
   assign prescale_step = ms_tick ? 8'd0 : prescale_inc;
   assign ms_timed      = (ms_tick && (ms_count_ff != 8'hFF)) ? ms_count_ff + 8'd1
                                                              : ms_count_ff;
   assign pulse_inc     = pulse_count_ff + 8'd1;
   assign echo_now      = echo_seen_ff | tick.sense_edge;

   always_comb begin
      phase_in           = phase_ff;
      prescale_in        = prescale_ff;
      ms_count_in        = ms_count_ff;
      pulse_count_in     = pulse_count_ff;
      burst_index_in     = burst_index_ff;
      echo_seen_in       = echo_seen_ff;
      run_length_in      = run_length_ff;
      gap_length_in      = gap_length_ff;
      button_timing_in   = button_timing_ff;
      button_reported_in = button_reported_ff;
      result             = '0;

      unique case (phase_ff)
         PH_IDLE: begin
            if (tick.running) begin
               phase_in         = PH_BURST;
               pulse_count_in   = 8'd0;
               burst_index_in   = 4'd0;
               echo_seen_in     = 1'b0;
               button_timing_in = 1'b0;
            end else if (!tick.key_down) begin
               button_timing_in   = 1'b0;
               button_reported_in = 1'b0;
               prescale_in        = 8'd0;
               ms_count_in        = 8'd0;
            end else if (!button_reported_ff) begin
               if (!button_timing_ff) begin
                  button_timing_in = 1'b1;
                  prescale_in      = 8'd0;
                  ms_count_in      = 8'd0;
               end else begin
                  prescale_in = prescale_step;
                  if (ms_tick) begin
                     if (ms_count_ff >= cfg.press_hold_ms) begin
                        result.button_event = 1'b1;
                        button_reported_in  = 1'b1;
                        button_timing_in    = 1'b0;
                     end else begin
                        ms_count_in = ms_count_ff + 8'd1;
                     end
                  end
               end
            end
         end
         PH_BURST: begin
            result.carrier_on = 1'b1;
            echo_seen_in      = echo_now;
            pulse_count_in    = pulse_inc;
            if (pulse_inc >= ppb) begin
               if (echo_now) begin
                  if (run_length_ff != 4'hF) run_length_in = run_length_ff + 4'd1;
               end else begin
                  run_length_in = 4'd0;
               end
               echo_seen_in   = 1'b0;
               gap_length_in  = tick.gap_random;
               burst_index_in = burst_index_ff + 4'd1;
               prescale_in    = 8'd0;
               ms_count_in    = 8'd0;
               phase_in       = PH_GAP;
            end
         end
         PH_GAP: begin
            prescale_in = prescale_step;
            ms_count_in = ms_timed;
            if (ms_timed >= {3'd0, gap_length_ff}) begin
               if (burst_index_ff < bpr) begin
                  phase_in       = PH_BURST;
                  pulse_count_in = 8'd0;
                  echo_seen_in   = 1'b0;
               end else begin
                  result.complete_event = (run_length_ff >= cfg.pass_threshold);
                  run_length_in         = 4'd0;
                  prescale_in           = 8'd0;
                  ms_count_in           = 8'd0;
                  phase_in              = PH_PING;
               end
            end
         end
         PH_PING: begin
            prescale_in = prescale_step;
            ms_count_in = ms_timed;
            if (ms_timed >= cfg.ping_gap_ms) begin
               if (tick.running) begin
                  phase_in         = PH_BURST;
                  pulse_count_in   = 8'd0;
                  burst_index_in   = 4'd0;
                  echo_seen_in     = 1'b0;
                  button_timing_in = 1'b0;
               end else begin
                  phase_in    = PH_IDLE;
                  prescale_in = 8'd0;
                  ms_count_in = 8'd0;
               end
            end
         end
         default: phase_in = PH_IDLE;
      endcase

      result.echo_run = run_length_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff           <= PH_IDLE;
         prescale_ff        <= 8'd0;
         ms_count_ff        <= 8'd0;
         pulse_count_ff     <= 8'd0;
         burst_index_ff     <= 4'd0;
         echo_seen_ff       <= 1'b0;
         run_length_ff      <= 4'd0;
         gap_length_ff      <= 5'd0;
         button_timing_ff   <= 1'b0;
         button_reported_ff <= 1'b0;
      end else if (step) begin
         phase_ff           <= phase_in;
         prescale_ff        <= prescale_in;
         ms_count_ff        <= ms_count_in;
         pulse_count_ff     <= pulse_count_in;
         burst_index_ff     <= burst_index_in;
         echo_seen_ff       <= echo_seen_in;
         run_length_ff      <= run_length_in;
         gap_length_ff      <= gap_length_in;
         button_timing_ff   <= button_timing_in;
         button_reported_ff <= button_reported_in;
      end
   end

endmodule : ibed_core

`default_nettype wire

// ===== bench/ir_burst_echo_checker.sv =====
// ----------------------------------------------------------------------------
// ir_burst_echo_checker
// Watches the tick and result channels and the register port of the infrared
// burst echo detector. Keeps its own copy of the round sequencer and of the
// timing registers, works out the result of every accepted tick and compares
// each accepted result with the oldest outstanding one, field by field.
// ----------------------------------------------------------------------------
module ir_burst_echo_checker (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   input  logic                               req_ready,
   input  logic                               req_sense_edge,
   input  logic                               req_key_down,
   input  logic                               req_running,
   input  logic [4:0]                         req_gap_random,
   input  logic                               rsp_valid,
   input  logic                               rsp_ready,
   input  logic                               rsp_carrier_on,
   input  logic                               rsp_button_event,
   input  logic                               rsp_complete_event,
   input  logic [3:0]                         rsp_echo_run,
   input  logic                               csr_we,
   input  logic [ibed_pkg::CsrIndexWidth-1:0] csr_index,
   input  logic [ibed_pkg::CsrDataWidth-1:0]  csr_wdata,
   output int unsigned                        fail_count,
   output int unsigned                        open_results
);
   timeunit 1ns;
   timeprecision 1ps;

   import ibed_pkg::*;

   typedef enum logic [1:0] {SEQ_IDLE, SEQ_BURST, SEQ_GAP, SEQ_PING} seq_phase_type;

   cfg_type       timing;
   seq_phase_type phase;
   logic [7:0]    prescale;
   logic [7:0]    ms_elapsed;
   logic [7:0]    pulses_done;
   logic [3:0]    burst_no;
   logic          echo_latch;
   logic [3:0]    run_len;
   logic [4:0]    gap_ms;
   logic          btn_timing;
   logic          btn_reported;

   result_type  due_results[$];
   int unsigned results_seen = 0;
   int unsigned mismatches   = 0;
   int unsigned pending      = 0;

   assign fail_count   = mismatches;
   assign open_results = pending;

   task automatic report_mismatch(input string msg);
      if (mismatches < 200)
         $display("[%0t] result %0d: %s", $time, results_seen, msg);
      mismatches++;
   endtask

   task automatic check_field(input string name, input logic [3:0] got,
                              input logic [3:0] want);
      if (got !== want)
         report_mismatch($sformatf("%s is %0d, expected %0d", name, got, want));
   endtask

   function automatic logic ms_strobe();
      logic [7:0] tpm;
      tpm = (timing.ticks_per_ms == 8'd0) ? 8'd1 : timing.ticks_per_ms;
      prescale = prescale + 8'd1;
      if (prescale >= tpm) begin
         prescale = 8'd0;
         return 1'b1;
      end
      return 1'b0;
   endfunction

   function automatic void restart_timer();
      prescale   = 8'd0;
      ms_elapsed = 8'd0;
   endfunction

   function automatic logic timer_expired(input logic [7:0] target);
      if (ms_strobe() && ms_elapsed != 8'hFF)
         ms_elapsed = ms_elapsed + 8'd1;
      return ms_elapsed >= target;
   endfunction

   function automatic void begin_round();
      phase       = SEQ_BURST;
      pulses_done = 8'd0;
      burst_no    = 4'd0;
      echo_latch  = 1'b0;
      btn_timing  = 1'b0;
   endfunction

   function automatic result_type predict_tick(input tick_type t);
      result_type r;
      logic [7:0] ppb;
      logic [3:0] bpr;
      r   = '0;
      ppb = (timing.pulses_per_burst == 8'd0) ? 8'd1 : timing.pulses_per_burst;
      bpr = (timing.bursts_per_round == 4'd0) ? 4'd1 : timing.bursts_per_round;
      case (phase)
         SEQ_IDLE: begin
            if (t.running) begin
               begin_round();
            end else if (!t.key_down) begin
               btn_timing   = 1'b0;
               btn_reported = 1'b0;
               restart_timer();
            end else if (!btn_reported) begin
               if (!btn_timing) begin
                  btn_timing = 1'b1;
                  restart_timer();
               end else if (ms_strobe()) begin
                  if (ms_elapsed >= timing.press_hold_ms) begin
                     r.button_event = 1'b1;
                     btn_reported   = 1'b1;
                     btn_timing     = 1'b0;
                  end else begin
                     ms_elapsed = ms_elapsed + 8'd1;
                  end
               end
            end
         end
         SEQ_BURST: begin
            r.carrier_on = 1'b1;
            if (t.sense_edge)
               echo_latch = 1'b1;
            pulses_done = pulses_done + 8'd1;
            if (pulses_done >= ppb) begin
               if (echo_latch) begin
                  if (run_len != 4'd15)
                     run_len = run_len + 4'd1;
               end else begin
                  run_len = 4'd0;
               end
               echo_latch = 1'b0;
               gap_ms     = t.gap_random;
               burst_no   = burst_no + 4'd1;
               restart_timer();
               phase = SEQ_GAP;
            end
         end
         SEQ_GAP: begin
            if (timer_expired({3'b000, gap_ms})) begin
               if (burst_no < bpr) begin
                  phase       = SEQ_BURST;
                  pulses_done = 8'd0;
                  echo_latch  = 1'b0;
               end else begin
                  if (run_len >= timing.pass_threshold)
                     r.complete_event = 1'b1;
                  run_len = 4'd0;
                  restart_timer();
                  phase = SEQ_PING;
               end
            end
         end
         default: begin
            if (timer_expired(timing.ping_gap_ms)) begin
               if (t.running) begin
                  begin_round();
               end else begin
                  phase = SEQ_IDLE;
                  restart_timer();
               end
            end
         end
      endcase
      r.echo_run = run_len;
      return r;
   endfunction

   always @(posedge clock) begin : watch
      result_type got;
      result_type want;
      if (reset) begin
         timing       = {RESET_TICKS_PER_MS, RESET_PULSES_PER_BURST,
                         RESET_BURSTS_PER_ROUND, RESET_PASS_THRESHOLD,
                         RESET_PING_GAP_MS, RESET_PRESS_HOLD_MS};
         phase        = SEQ_IDLE;
         prescale     = 8'd0;
         ms_elapsed   = 8'd0;
         pulses_done  = 8'd0;
         burst_no     = 4'd0;
         echo_latch   = 1'b0;
         run_len      = 4'd0;
         gap_ms       = 5'd0;
         btn_timing   = 1'b0;
         btn_reported = 1'b0;
         due_results.delete();
      end else begin
         if (csr_we) begin
            case (csr_index)
               CSR_TICKS_PER_MS:     timing.ticks_per_ms     = csr_wdata;
               CSR_PULSES_PER_BURST: timing.pulses_per_burst = csr_wdata;
               CSR_BURSTS_PER_ROUND: timing.bursts_per_round = csr_wdata[3:0];
               CSR_PASS_THRESHOLD:   timing.pass_threshold   = csr_wdata[3:0];
               CSR_PING_GAP_MS:      timing.ping_gap_ms      = csr_wdata;
               CSR_PRESS_HOLD_MS:    timing.press_hold_ms    = csr_wdata;
               default: ;
            endcase
         end
         if (rsp_valid && rsp_ready) begin
            got = {rsp_carrier_on, rsp_button_event, rsp_complete_event, rsp_echo_run};
            if (due_results.size() == 0) begin
               report_mismatch("result transaction with nothing outstanding");
            end else begin
               want = due_results.pop_front();
               check_field("carrier_on", got.carrier_on, want.carrier_on);
               check_field("button_event", got.button_event, want.button_event);
               check_field("complete_event", got.complete_event, want.complete_event);
               check_field("echo_run", got.echo_run, want.echo_run);
            end
            results_seen++;
         end
         if (req_valid && req_ready)
            due_results.push_back(predict_tick({req_sense_edge, req_key_down,
                                                req_running, req_gap_random}));
      end
      pending <= due_results.size();
   end

endmodule

// ===== bench/tb_ir_burst_echo_detector_unit.sv =====
// ----------------------------------------------------------------------------
// tb_ir_burst_echo_detector_unit
// Drives ticks into the infrared burst echo detector under a series of timing
// settings: reset defaults, all-zero and all-ones registers, a full round of
// echoed bursts, long debounce and ping pauses, and randomised short timings
// with random stalls on both channels. The checker beside the block predicts
// and compares every result; this module gives the verdict.
// ----------------------------------------------------------------------------
module tb_ir_burst_echo_detector_unit;
   timeunit 1ns;
   timeprecision 1ps;

   import ibed_pkg::*;

   logic                     clock              = 1'b0;
   logic                     reset              = 1'b1;
   logic                     req_valid          = 1'b0;
   logic                     req_ready;
   logic                     req_sense_edge     = 1'b0;
   logic                     req_key_down       = 1'b0;
   logic                     req_running        = 1'b0;
   logic [4:0]               req_gap_random     = 5'd0;
   logic                     rsp_valid;
   logic                     rsp_ready          = 1'b0;
   logic                     rsp_carrier_on;
   logic                     rsp_button_event;
   logic                     rsp_complete_event;
   logic [3:0]               rsp_echo_run;
   logic                     csr_we             = 1'b0;
   logic [CsrIndexWidth-1:0] csr_index          = '0;
   logic [CsrDataWidth-1:0]  csr_wdata          = '0;
   int unsigned              fail_count;
   int unsigned              open_results;

   logic run_level   = 1'b0;
   logic press_level = 1'b0;
   int   run_left    = 0;
   int   press_left  = 0;

   ir_burst_echo_detector_unit u_dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_sense_edge     (req_sense_edge),
      .req_key_down       (req_key_down),
      .req_running        (req_running),
      .req_gap_random     (req_gap_random),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_carrier_on     (rsp_carrier_on),
      .rsp_button_event   (rsp_button_event),
      .rsp_complete_event (rsp_complete_event),
      .rsp_echo_run       (rsp_echo_run),
      .csr_we             (csr_we),
      .csr_index          (csr_index),
      .csr_wdata          (csr_wdata)
   );

   ir_burst_echo_checker u_checker (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_sense_edge     (req_sense_edge),
      .req_key_down       (req_key_down),
      .req_running        (req_running),
      .req_gap_random     (req_gap_random),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_carrier_on     (rsp_carrier_on),
      .rsp_button_event   (rsp_button_event),
      .rsp_complete_event (rsp_complete_event),
      .rsp_echo_run       (rsp_echo_run),
      .csr_we             (csr_we),
      .csr_index          (csr_index),
      .csr_wdata          (csr_wdata),
      .fail_count         (fail_count),
      .open_results       (open_results)
   );

   always #6 clock = ~clock;

   function automatic int idle_len();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55)
         return 0;
      if (r < 88)
         return $urandom_range(1, 3);
      return $urandom_range(4, 40);
   endfunction

   task automatic load_timing(input logic [7:0] tpm, input logic [7:0] ppb,
                              input logic [7:0] bpr, input logic [7:0] thr,
                              input logic [7:0] ping, input logic [7:0] deb);
      logic [CsrDataWidth-1:0]  vals [6];
      logic [CsrIndexWidth-1:0] regs [6];
      vals = '{tpm, ppb, bpr, thr, ping, deb};
      regs = '{CSR_TICKS_PER_MS, CSR_PULSES_PER_BURST, CSR_BURSTS_PER_ROUND,
               CSR_PASS_THRESHOLD, CSR_PING_GAP_MS, CSR_PRESS_HOLD_MS};
      for (int i = 0; i < 6; i++) begin
         csr_we    <= 1'b1;
         csr_index <= regs[i];
         csr_wdata <= vals[i];
         @(posedge clock);
      end
      csr_we <= 1'b0;
   endtask

   task automatic send_tick(input logic sense, input logic press, input logic run,
                            input logic [4:0] gap_ms);
      int gap;
      req_valid      <= 1'b1;
      req_sense_edge <= sense;
      req_key_down   <= press;
      req_running    <= run;
      req_gap_random <= gap_ms;
      @(posedge clock);
      while (!req_ready)
         @(posedge clock);
      gap = idle_len();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic play_ticks(input int count, input int edge_pct, input int gap_max,
                             input int run_pct, input int press_hold);
      logic [4:0] gap_ms;
      for (int n = 0; n < count; n++) begin
         if (run_left <= 0) begin
            run_level = ($urandom_range(0, 99) < run_pct);
            run_left  = $urandom_range(1, 80);
         end
         if (press_left <= 0) begin
            press_level = ~press_level;
            press_left  = $urandom_range(1, press_hold);
         end
         if ($urandom_range(0, 9) == 0)
            gap_ms = 5'($urandom_range(0, 31));
         else
            gap_ms = 5'($urandom_range(0, gap_max));
         send_tick($urandom_range(0, 99) < edge_pct, press_level, run_level, gap_ms);
         run_left--;
         press_left--;
      end
   endtask

   task automatic settle();
      int waited;
      if (req_valid)
         req_valid <= 1'b0;
      @(posedge clock);
      waited = 0;
      while (open_results != 0 && waited < 5000) begin
         @(posedge clock);
         waited++;
      end
   endtask

   initial begin : rsp_pacing
      int hold;
      @(posedge clock);
      while (reset)
         @(posedge clock);
      forever begin
         rsp_ready <= 1'b1;
         repeat ($urandom_range(1, 40)) @(posedge clock);
         hold = idle_len();
         if (hold > 0) begin
            rsp_ready <= 1'b0;
            repeat (hold) @(posedge clock);
         end
      end
   end

   initial begin : watchdog
      #20_000_000;
      $display("Regression FAIL");
      $finish;
   end

   initial begin : stimulus
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // reset defaults
      play_ticks(40, 50, 3, 50, 20);
      settle();

      // all registers zero: zero acts as one where it would stall
      load_timing(8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0);
      send_tick(1'b0, 1'b1, 1'b0, 5'd0);
      send_tick(1'b0, 1'b1, 1'b0, 5'd0);
      send_tick(1'b0, 1'b1, 1'b0, 5'd0);
      send_tick(1'b0, 1'b0, 1'b0, 5'd0);
      send_tick(1'b0, 1'b1, 1'b0, 5'd0);
      send_tick(1'b0, 1'b1, 1'b0, 5'd0);
      send_tick(1'b1, 1'b1, 1'b1, 5'd31);
      send_tick(1'b1, 1'b0, 1'b1, 5'd0);
      send_tick(1'b0, 1'b0, 1'b1, 5'd0);
      send_tick(1'b0, 1'b0, 1'b1, 5'd0);
      send_tick(1'b0, 1'b0, 1'b0, 5'd1);
      send_tick(1'b1, 1'b0, 1'b0, 5'd0);
      send_tick(1'b0, 1'b1, 1'b0, 5'd0);
      send_tick(1'b0, 1'b1, 1'b0, 5'd0);
      send_tick(1'b0, 1'b1, 1'b0, 5'd0);
      send_tick(1'b0, 1'b0, 1'b0, 5'd0);
      send_tick(1'b0, 1'b1, 1'b0, 5'd0);
      send_tick(1'b0, 1'b1, 1'b0, 5'd0);
      send_tick(1'b1, 1'b1, 1'b1, 5'd31);
      send_tick(1'b0, 1'b0, 1'b0, 5'd2);
      settle();

      // short random timings
      repeat (5) begin
         load_timing(8'($urandom_range(0, 3)), 8'($urandom_range(0, 5)),
                     8'($urandom_range(0, 6)), 8'($urandom_range(0, 7)),
                     8'($urandom_range(0, 4)), 8'($urandom_range(0, 6)));
         play_ticks(150, $urandom_range(30, 95), 3, 85, 30);
         settle();
      end

      // full round of echoed bursts up to the run-length ceiling
      load_timing(8'd1, 8'd1, 8'd15, 8'd15, 8'd0, 8'd0);
      play_ticks(200, 100, 0, 100, 50);
      settle();

      // longest debounce and ping pause
      load_timing(8'd1, 8'd2, 8'd2, 8'd1, 8'd255, 8'd255);
      play_ticks(350, 60, 3, 10, 400);
      settle();

      // all register bits set
      load_timing(8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
      play_ticks(100, 50, 31, 50, 100);
      settle();

      repeat (4) @(posedge clock);
      if (fail_count == 0 && open_results == 0)
         $display("Regression PASS");
      else
         $display("Regression FAIL");
      $finish;
   end

endmodule
